/* rtl/core/qrsbp_pkg.sv */
// ============================================================================
// qrsbp_pkg
// Shared types, codes and lookup functions for the QR segment bit packer.
// ============================================================================
package qrsbp_pkg;

    localparam int ACC_W       = 27;
    localparam int PUSH_W      = 20;
    localparam int NRESULTS    = 3;
    localparam int NUM_RADIX   = 10;
    localparam int ALNUM_RADIX = 45;

    localparam logic [7:0]  PAD_BYTE_A = 8'd236;
    localparam logic [7:0]  PAD_BYTE_B = 8'd17;
    localparam logic [11:0] BYTES_MAX  = 12'hFFF;
    localparam logic [11:0] CODEWORDS_RESET = 12'd19;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_CHAR   = 3'd1,
        MODE_END    = 3'd2,
        MODE_FINISH = 3'd3,
        MODE_PAD    = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        SEG_NUMERIC = 2'd0,
        SEG_ALNUM   = 2'd1,
        SEG_BYTE    = 2'd2
    } seg_kind_t;

    typedef enum logic [1:0] {
        STATUS_DATA = 2'd0,
        STATUS_PAD  = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic {
        CFG_VERSION_GROUP  = 1'b0,
        CFG_DATA_CODEWORDS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       err;
        logic       last;
    } result_t;

    typedef struct packed {
        result_t [NRESULTS-1:0] entry;
        logic [1:0]             count;
    } batch_t;

    typedef struct packed {
        logic        valid;
        logic        index;
        logic [11:0] data;
    } cfg_write_t;

    function automatic logic [4:0] count_width(input logic [1:0] grp, input seg_kind_t kind);
        logic [4:0] w;
        w = 5'd8;
        unique case (grp)
            2'd0:
            begin
                unique case (kind)
                    SEG_NUMERIC: w = 5'd10;
                    SEG_ALNUM:   w = 5'd9;
                    default:     w = 5'd8;
                endcase
            end
            2'd1:
            begin
                unique case (kind)
                    SEG_NUMERIC: w = 5'd12;
                    SEG_ALNUM:   w = 5'd11;
                    default:     w = 5'd16;
                endcase
            end
            default:
            begin
                unique case (kind)
                    SEG_NUMERIC: w = 5'd14;
                    SEG_ALNUM:   w = 5'd13;
                    default:     w = 5'd16;
                endcase
            end
        endcase
        return w;
    endfunction

    // {valid, code}
    function automatic logic [6:0] alnum_code(input logic [7:0] ch);
        logic [6:0] r;
        r = 7'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            r = {1'b1, 6'(ch - 8'h30)};
        end
        else if (ch >= 8'h41 && ch <= 8'h5A)
        begin
            r = {1'b1, 6'(ch - 8'h41 + 8'd10)};
        end
        else
        begin
            unique case (ch)
                8'h20:   r = {1'b1, 6'd36};
                8'h24:   r = {1'b1, 6'd37};
                8'h25:   r = {1'b1, 6'd38};
                8'h2A:   r = {1'b1, 6'd39};
                8'h2B:   r = {1'b1, 6'd40};
                8'h2D:   r = {1'b1, 6'd41};
                8'h2E:   r = {1'b1, 6'd42};
                8'h2F:   r = {1'b1, 6'd43};
                8'h3A:   r = {1'b1, 6'd44};
                default: r = 7'd0;
            endcase
        end
        return r;
    endfunction

endpackage

/* rtl/core/qrsbp_packer_core.sv */
// ============================================================================
// qrsbp_packer_core
// Packing state, configuration registers and the single-pass encode logic
// that turns one registered item into a batch of up to three result bytes.
// ============================================================================
module qrsbp_packer_core
    import qrsbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_write_t  cfg,
    input  logic        go,
    input  logic [2:0]  mode,
    input  logic [1:0]  seg_type,
    input  logic [15:0] seg_length,
    input  logic [7:0]  character,
    output batch_t      batch
);

    logic [1:0]  version_group_reg;
    logic [11:0] data_codewords_reg;

    logic [6:0]  bit_holder_reg,   bit_holder_next;
    logic [2:0]  bit_count_reg,    bit_count_next;
    logic [10:0] group_value_reg,  group_value_next;
    logic [1:0]  group_fill_reg,   group_fill_next;
    seg_kind_t   segment_kind_reg, segment_kind_next;
    logic [11:0] bytes_out_reg,    bytes_out_next;
    logic        pad_phase_reg,    pad_phase_next;
    logic        err_latch_reg,    err_latch_next;

    logic [PUSH_W-1:0] push_val;
    logic [4:0]        push_n;
    logic              pre_err;
    logic              post_err;
    logic              is_pad;
    seg_kind_t         kind_sel;
    logic [1:0]        grp;
    logic [4:0]        cw;
    logic [15:0]       len_mask;
    logic [3:0]        indicator;
    logic [14:0]       num_prod;
    logic [10:0]       num_val;
    logic [6:0]        acode;
    logic [16:0]       alnum_prod;
    logic [6:0]        flush_val;
    logic [2:0]        flush_n;
    logic [2:0]        fill_n;
    logic [ACC_W-1:0]  acc;
    logic [4:0]        total;
    logic [1:0]        nbytes;
    logic [ACC_W-1:0]  shifted [NRESULTS];
    logic [7:0]        pad_data;
    status_t           pad_status;
    logic [1:0]        bytes_inc;
    logic [12:0]       bytes_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_group_reg  <= 2'd0;
            data_codewords_reg <= CODEWORDS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.index))
                CFG_VERSION_GROUP:  version_group_reg  <= cfg.data[1:0];
                CFG_DATA_CODEWORDS: data_codewords_reg <= cfg.data;
            endcase
        end
    end

    // flush of a partial character group
    always_comb
    begin
        flush_val = 7'd0;
        flush_n   = 3'd0;
        if (group_fill_reg != 2'd0)
        begin
            unique case (segment_kind_reg)
                SEG_NUMERIC:
                begin
                    if (group_fill_reg == 2'd2)
                    begin
                        flush_val = group_value_reg[6:0];
                        flush_n   = 3'd7;
                    end
                    else
                    begin
                        flush_val = {3'd0, group_value_reg[3:0]};
                        flush_n   = 3'd4;
                    end
                end
                SEG_ALNUM:
                begin
                    flush_val = {1'b0, group_value_reg[5:0]};
                    flush_n   = 3'd6;
                end
                default:
                begin
                    flush_val = 7'd0;
                    flush_n   = 3'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        push_val          = '0;
        push_n            = 5'd0;
        pre_err           = 1'b0;
        post_err          = 1'b0;
        is_pad            = 1'b0;
        group_value_next  = group_value_reg;
        group_fill_next   = group_fill_reg;
        segment_kind_next = segment_kind_reg;
        pad_phase_next    = pad_phase_reg;

        kind_sel  = (seg_type == 2'd3) ? SEG_BYTE : seg_kind_t'(seg_type);
        grp       = (version_group_reg == 2'd3) ? 2'd2 : version_group_reg;
        cw        = count_width(grp, kind_sel);
        len_mask  = 16'((17'd1 << cw) - 17'd1);
        indicator = 4'(4'd1 << kind_sel);
        num_prod  = 15'(group_value_reg) * 15'(NUM_RADIX);
        num_val   = 11'(num_prod + 15'((character >= 8'h30 && character <= 8'h39)
                                       ? character - 8'h30 : 8'd0));
        acode     = alnum_code(character);
        alnum_prod = 17'(group_value_reg) * 17'(ALNUM_RADIX) + 17'(acode[5:0]);
        fill_n    = 3'(3'd0 - 3'(bit_count_reg + flush_n + 3'd4));

        unique case (mode)
            MODE_START:
            begin
                pre_err           = (seg_type == 2'd3) || ((seg_length & ~len_mask) != 16'd0);
                push_val          = (PUSH_W'(indicator) << cw) | PUSH_W'(seg_length & len_mask);
                push_n            = 5'd4 + cw;
                segment_kind_next = kind_sel;
                group_value_next  = 11'd0;
                group_fill_next   = 2'd0;
            end
            MODE_CHAR:
            begin
                unique case (segment_kind_reg)
                    SEG_NUMERIC:
                    begin
                        post_err = !(character >= 8'h30 && character <= 8'h39);
                        if (group_fill_reg >= 2'd2)
                        begin
                            push_val         = PUSH_W'(num_val[9:0]);
                            push_n           = 5'd10;
                            group_value_next = 11'd0;
                            group_fill_next  = 2'd0;
                        end
                        else
                        begin
                            group_value_next = num_val;
                            group_fill_next  = group_fill_reg + 2'd1;
                        end
                    end
                    SEG_ALNUM:
                    begin
                        post_err = !acode[6];
                        if (group_fill_reg == 2'd0)
                        begin
                            group_value_next = 11'(acode[5:0]);
                            group_fill_next  = 2'd1;
                        end
                        else
                        begin
                            push_val         = PUSH_W'(alnum_prod[10:0]);
                            push_n           = 5'd11;
                            group_value_next = 11'd0;
                            group_fill_next  = 2'd0;
                        end
                    end
                    default:
                    begin
                        push_val = PUSH_W'(character);
                        push_n   = 5'd8;
                    end
                endcase
            end
            MODE_END:
            begin
                push_val         = PUSH_W'(flush_val);
                push_n           = 5'(flush_n);
                group_value_next = 11'd0;
                group_fill_next  = 2'd0;
            end
            MODE_FINISH:
            begin
                push_val         = PUSH_W'(flush_val) << (5'd4 + 5'(fill_n));
                push_n           = 5'(flush_n) + 5'd4 + 5'(fill_n);
                group_value_next = 11'd0;
                group_fill_next  = 2'd0;
                pad_phase_next   = 1'b0;
            end
            MODE_PAD:
            begin
                is_pad = 1'b1;
            end
            default:
            begin
                is_pad = 1'b0;
            end
        endcase

        acc             = (ACC_W'(bit_holder_reg) << push_n) | ACC_W'(push_val);
        total           = 5'(bit_count_reg) + push_n;
        nbytes          = total[4:3];
        bit_count_next  = total[2:0];
        bit_holder_next = 7'(acc & ((ACC_W'(1) << total[2:0]) - ACC_W'(1)));

        for (int k = 0; k < NRESULTS; k++)
        begin
            shifted[k] = acc >> (total - 5'(8 * (k + 1)));
        end

        if (bytes_out_reg < data_codewords_reg)
        begin
            pad_data   = pad_phase_reg ? PAD_BYTE_B : PAD_BYTE_A;
            pad_status = STATUS_PAD;
        end
        else
        begin
            pad_data   = 8'd0;
            pad_status = STATUS_FULL;
        end

        batch = '0;
        if (is_pad)
        begin
            batch.count          = 2'd1;
            batch.entry[0].data  = pad_data;
            batch.entry[0].status = pad_status;
            if (pad_status == STATUS_PAD)
            begin
                pad_phase_next = !pad_phase_reg;
            end
            bytes_inc = (pad_status == STATUS_PAD) ? 2'd1 : 2'd0;
        end
        else
        begin
            batch.count = nbytes;
            for (int k = 0; k < NRESULTS; k++)
            begin
                batch.entry[k].data   = shifted[k][7:0];
                batch.entry[k].status = STATUS_DATA;
            end
            bytes_inc = nbytes;
        end
        batch.entry[0].err = err_latch_reg | pre_err;
        for (int k = 0; k < NRESULTS; k++)
        begin
            batch.entry[k].last = (2'(k + 1) == batch.count);
        end

        err_latch_next = (batch.count != 2'd0) ? post_err
                                               : (err_latch_reg | pre_err | post_err);
        bytes_sum      = 13'(bytes_out_reg) + 13'(bytes_inc);
        bytes_out_next = (bytes_sum > 13'(BYTES_MAX)) ? BYTES_MAX : bytes_sum[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_holder_reg   <= 7'd0;
            bit_count_reg    <= 3'd0;
            group_value_reg  <= 11'd0;
            group_fill_reg   <= 2'd0;
            segment_kind_reg <= SEG_NUMERIC;
            bytes_out_reg    <= 12'd0;
            pad_phase_reg    <= 1'b0;
            err_latch_reg    <= 1'b0;
        end
        else if (go)
        begin
            bit_holder_reg   <= bit_holder_next;
            bit_count_reg    <= bit_count_next;
            group_value_reg  <= group_value_next;
            group_fill_reg   <= group_fill_next;
            segment_kind_reg <= segment_kind_next;
            bytes_out_reg    <= bytes_out_next;
            pad_phase_reg    <= pad_phase_next;
            err_latch_reg    <= err_latch_next;
        end
    end

endmodule

/* rtl/core/qrsbp_out_queue.sv */
// ============================================================================
// qrsbp_out_queue
// Three-entry result register: loads a whole batch, drains one transfer
// per cycle from its head while out_stall is low.
// ============================================================================
module qrsbp_out_queue
    import qrsbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  batch_t     batch,
    output logic       load_ok,
    output logic       out_valid,
    input  logic       out_stall,
    output result_t    head
);

    logic [1:0] count_reg, count_next;
    result_t    entry_reg [NRESULTS];
    logic       pop;

    always_comb
    begin
        pop       = (count_reg != 2'd0) && !out_stall;
        load_ok   = (count_reg == 2'd0) || ((count_reg == 2'd1) && !out_stall);
        out_valid = (count_reg != 2'd0);
        head      = entry_reg[0];
        if (load)
        begin
            count_next = batch.count;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < NRESULTS; k++)
            begin
                entry_reg[k] <= batch.entry[k];
            end
        end
        else if (pop)
        begin
            // advance
            for (int k = 0; k < NRESULTS - 1; k++)
            begin
                entry_reg[k] <= entry_reg[k + 1];
            end
        end
    end

endmodule

/* rtl/core/qr_segment_bit_packer.sv */
// ============================================================================
// qr_segment_bit_packer
// QR data-segment bit packer: items in, MSB-first codeword bytes out.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: mode,
//   seg_type, seg_length and character. Output channel (out_valid /
//   out_stall) carries one result per transfer: out_byte, status,
//   input_error, last_of_run. last_of_run marks the final result of an item.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   version_group (index 0) or data_codewords (index 1); cfg_ready is always
//   high. Write it only while no item is in flight.
//   An accepted item is held in the input register, where it is encoded
//   combinationally; its results then load the output register.
//   Throughput: one item per cycle while out_stall is low and each item
//   gives at most one result. A two- or three-byte item occupies the output
//   register for that many transfers; the next waits in the input register.
//   Reset clears all packing state, sets version_group 0 and data_codewords
//   19 and empties both registers. A stalled receiver holds the head result
//   and backs up into in_stall once the input register is full.
// ============================================================================
module qr_segment_bit_packer
    import qrsbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [1:0]  seg_type,
    input  logic [15:0] seg_length,
    input  logic [7:0]  character,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [1:0]  status,
    output logic        input_error,
    output logic        last_of_run,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);

    logic        in_valid_reg;
    logic [2:0]  mode_reg;
    logic [1:0]  seg_type_reg;
    logic [15:0] seg_length_reg;
    logic [7:0]  character_reg;

    logic        load_ok;
    logic        go;
    batch_t      batch;
    result_t     head;
    cfg_write_t  cfg;

    assign cfg_ready = 1'b1;
    assign cfg       = '{valid: cfg_valid & cfg_ready, index: cfg_index, data: cfg_data};
    assign go        = in_valid_reg & load_ok;
    assign in_stall  = in_valid_reg & ~load_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg       <= mode;
            seg_type_reg   <= seg_type;
            seg_length_reg <= seg_length;
            character_reg  <= character;
        end
    end

    qrsbp_packer_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .go         (go),
        .mode       (mode_reg),
        .seg_type   (seg_type_reg),
        .seg_length (seg_length_reg),
        .character  (character_reg),
        .batch      (batch)
    );

    qrsbp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (go),
        .batch     (batch),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign out_byte    = head.data;
    assign status      = head.status;
    assign input_error = head.err;
    assign last_of_run = head.last;

endmodule

/* rtl/core/qrsbp_checker.sv */
// ============================================================================
// qrsbp_checker
// Port-level checks on the output channel of the segment bit packer.
// ============================================================================
module qrsbp_checker
    import qrsbp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic [1:0] status,
    input logic       last_of_run
);

    // hold a stalled transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(status))
        else $error("stalled output transfer changed");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FULL |-> out_byte == 8'd0)
        else $error("capacity result carries a nonzero byte");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_DATA || status == STATUS_PAD || status == STATUS_FULL)
        else $error("undefined status code");

    a_pad_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_DATA |-> last_of_run)
        else $error("pad or capacity result not last of its run");

endmodule

bind qr_segment_bit_packer qrsbp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .status      (status),
    .last_of_run (last_of_run)
);
